// ===== rtl/packet_timestamp_normalizer_macros.svh =====
// assertion helpers
`ifndef PACKET_TIMESTAMP_NORMALIZER_MACROS_SVH
`define PACKET_TIMESTAMP_NORMALIZER_MACROS_SVH
`ifndef SYNTHESIS
`define PTN_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define PTN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define PTN_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PTN_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/ptn_pkg.sv =====
package ptn_pkg;
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DTS_MUL,
		ST_DTS_DIV,
		ST_PTS_MUL,
		ST_PTS_DIV,
		ST_FINISH,
		ST_OUT
	} state_t;

	localparam logic [1:0] REG_NUM  = 2'd0;
	localparam logic [1:0] REG_DEN  = 2'd1;
	localparam logic [1:0] REG_RATE = 2'd2;
	localparam logic [1:0] REG_STEP = 2'd3;

	localparam int MulCycles = 4;
	localparam int DivBits   = 128;

	typedef struct packed {
		logic load;
		logic start_mul;
		logic mul_step;
		logic start_div;
		logic div_step;
		logic save_dts;
		logic save_pts;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
	} stat_t;
endpackage

// ===== rtl/ptn_ctrl.sv =====
module ptn_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_go,
	input  logic            dts_p,
	input  logic            pts_p,
	input  logic            out_taken,
	input  ptn_pkg::stat_t  stat,
	output ptn_pkg::cmd_t   cmd,
	output logic            busy,
	output logic            out_valid
);
	ptn_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ptn_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ptn_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (in_go) begin
					cmd.load = 1'b1;
					if (dts_p) begin
						cmd.start_mul = 1'b1;
						state_d = ptn_pkg::ST_DTS_MUL;
					end else if (pts_p) begin
						cmd.start_mul = 1'b1;
						state_d = ptn_pkg::ST_PTS_MUL;
					end else state_d = ptn_pkg::ST_FINISH;
				end
			end
			ptn_pkg::ST_DTS_MUL, ptn_pkg::ST_PTS_MUL: begin
				cmd.mul_step = 1'b1;
				if (stat.mul_done) begin
					cmd.start_div = 1'b1;
					state_d = (state_q == ptn_pkg::ST_DTS_MUL) ? ptn_pkg::ST_DTS_DIV
						: ptn_pkg::ST_PTS_DIV;
				end
			end
			ptn_pkg::ST_DTS_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) begin
					cmd.save_dts = 1'b1;
					if (pts_p) begin
						cmd.start_mul = 1'b1;
						state_d = ptn_pkg::ST_PTS_MUL;
					end else state_d = ptn_pkg::ST_FINISH;
				end
			end
			ptn_pkg::ST_PTS_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) begin
					cmd.save_pts = 1'b1;
					state_d = ptn_pkg::ST_FINISH;
				end
			end
			ptn_pkg::ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d = ptn_pkg::ST_OUT;
			end
			ptn_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_taken) state_d = ptn_pkg::ST_IDLE;
			end
			default: state_d = ptn_pkg::ST_IDLE;
		endcase
	end
endmodule

// ===== rtl/ptn_datapath.sv =====
module ptn_datapath #(
	parameter int STAMP_BITS = 63
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ptn_pkg::cmd_t      cmd,
	output ptn_pkg::stat_t     stat,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [31:0]        cfg_wdata,
	input  logic               pts_present,
	input  logic signed [62:0] pts_in,
	input  logic               dts_present,
	input  logic signed [62:0] dts_in,
	output logic signed [62:0] pts_out,
	output logic signed [62:0] dts_out,
	output logic               pts_made_up,
	output logic               pts_bumped,
	output logic               dts_bumped,
	output logic               pts_raised_to_dts
);
	localparam logic signed [63:0] SMax = 64'sd1 <<< (STAMP_BITS - 1);
	localparam logic signed [63:0] SMaxV = SMax - 64'sd1;
	localparam logic signed [63:0] SMinV = -SMax;

	logic [30:0] num_q, den_q, rate_q;
	logic [31:0] step_q;
	logic        pp_q, dp_q;
	logic signed [62:0] pin_q, din_q;
	logic signed [63:0] last_pts_q, last_dts_q, pts_r_q, dts_r_q;
	logic        lpv_q, ldv_q;

	// rescale working regs
	logic        neg_q;
	logic [61:0] k_q;
	logic [63:0] a_q;
	logic [127:0] prod_q;
	logic [1:0]  mcnt_q;
	logic [127:0] dq_q;
	logic [31:0] rem_q;
	logic [7:0]  dcnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= 31'd1;
			den_q <= 31'd90000;
			rate_q <= 31'd90000;
			step_q <= 32'd3000;
		end else if (cfg_we) begin
			case (cfg_idx)
				ptn_pkg::REG_NUM:  num_q <= cfg_wdata[30:0];
				ptn_pkg::REG_DEN:  den_q <= cfg_wdata[30:0];
				ptn_pkg::REG_RATE: rate_q <= cfg_wdata[30:0];
				ptn_pkg::REG_STEP: step_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// k = num * rate, one 31x31 multiply at load
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pp_q <= pts_present;
			dp_q <= dts_present;
			pin_q <= pts_in;
			din_q <= dts_in;
			k_q <= num_q * rate_q;
		end
	end

	logic signed [62:0] src_sel;
	logic [62:0] mag_in;
	assign src_sel = cmd.load ? dts_in : (pp_q ? pin_q : din_q);
	assign mag_in = src_sel[62] ? (~src_sel + 63'd1) : src_sel;

	logic [31:0] den_eff;
	assign den_eff = (den_q == 31'd0) ? 32'd1 : {1'b0, den_q};

	logic [32:0] rem_sh;
	logic [32:0] rem_sub;
	assign rem_sh = {rem_q, dq_q[127]};
	assign rem_sub = rem_sh - {1'b0, den_eff};

	// multiply: 63-bit magnitude times 62-bit k, one 16-bit slice of a per cycle
	logic [15:0] a_slice;
	logic [77:0] pprod;
	assign a_slice = a_q[{mcnt_q, 4'd0} +: 16];
	assign pprod = a_slice * k_q;

	always_ff @(posedge clk) begin
		if (cmd.start_mul) begin
			a_q <= {1'b0, (cmd.load ? (dts_present ? ((dts_in[62]) ? (~dts_in + 63'd1)
				: dts_in) : ((pts_in[62]) ? (~pts_in + 63'd1) : pts_in)) : mag_in)};
			neg_q <= cmd.load ? (dts_present ? dts_in[62] : pts_in[62]) : src_sel[62];
			prod_q <= '0;
			mcnt_q <= 2'd0;
		end else if (cmd.mul_step) begin
			prod_q <= prod_q + ({50'd0, pprod} << {mcnt_q, 4'd0});
			mcnt_q <= mcnt_q + 2'd1;
		end
		if (cmd.start_div) begin
			dq_q <= prod_q + ({50'd0, pprod} << {mcnt_q, 4'd0});
			rem_q <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			if (!rem_sub[32]) begin
				rem_q <= rem_sub[31:0];
				dq_q <= {dq_q[126:0], 1'b1};
			end else begin
				rem_q <= rem_sh[31:0];
				dq_q <= {dq_q[126:0], 1'b0};
			end
			dcnt_q <= dcnt_q + 8'd1;
		end
	end

	assign stat.mul_done = (mcnt_q == 2'(ptn_pkg::MulCycles - 1));
	assign stat.div_done = (dcnt_q == 8'(ptn_pkg::DivBits - 1));

	// final bit of division inline
	logic        qbit;
	logic [31:0] rem_fin;
	logic [127:0] q_fin;
	logic [128:0] q_rnd;
	logic [63:0] lim, mag_sat;
	logic signed [63:0] rescaled;
	assign qbit = !rem_sub[32];
	assign rem_fin = qbit ? rem_sub[31:0] : rem_sh[31:0];
	assign q_fin = {dq_q[126:0], qbit};
	assign q_rnd = {1'b0, q_fin} + (({1'b0, rem_fin} << 1) >= {1'b0, den_eff} ? 129'd1 : 129'd0);
	assign lim = neg_q ? 64'(SMax) : 64'(SMaxV);
	assign mag_sat = (q_rnd[128:64] != '0 || q_rnd[63:0] > lim) ? lim : q_rnd[63:0];
	assign rescaled = neg_q ? -$signed(mag_sat) : $signed(mag_sat);

	always_ff @(posedge clk) begin
		if (cmd.save_dts) dts_r_q <= rescaled;
		if (cmd.save_pts) pts_r_q <= rescaled;
	end

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s > 65'(SMaxV)) return SMaxV;
		if (s < 65'(SMinV)) return SMinV;
		return s[63:0];
	endfunction

	logic signed [63:0] p0, p1, d0, d1;
	logic mu, pb, db, rz;
	always_comb begin
		mu = !pp_q;
		if (pp_q) p0 = pts_r_q;
		else if (dp_q) p0 = dts_r_q;
		else if (lpv_q) p0 = sat_add(last_pts_q, $signed({32'd0, step_q}));
		else p0 = '0;
		pb = lpv_q && (p0 <= last_pts_q);
		p1 = pb ? sat_add(last_pts_q, 64'sd1) : p0;
		d0 = dp_q ? dts_r_q : p1;
		db = ldv_q && (d0 <= last_dts_q);
		d1 = db ? sat_add(last_dts_q, 64'sd1) : d0;
		rz = p1 < d1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lpv_q <= 1'b0;
			ldv_q <= 1'b0;
			last_pts_q <= '0;
			last_dts_q <= '0;
		end else if (cmd.finish) begin
			lpv_q <= 1'b1;
			ldv_q <= 1'b1;
			last_pts_q <= p1;
			last_dts_q <= d1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			pts_out <= rz ? d1[62:0] : p1[62:0];
			dts_out <= d1[62:0];
			pts_made_up <= mu;
			pts_bumped <= pb;
			dts_bumped <= db;
			pts_raised_to_dts <= rz;
		end
	end
endmodule

// ===== rtl/packet_timestamp_normalizer.sv =====
// packet timestamp normalizer
// input channel: in_valid/in_stall carries one packet's pts/dts with present flags
// output channel: out_valid/out_stall carries the normalized pair and four flags
// each present stamp is rescaled by a sliced multiply followed by a 128-bit
// restoring division, one quotient bit per cycle, in a shared unit
// one packet is in flight at a time; in_stall is high from accept until the
// result beat is taken, so no new packet is taken before the last one is out
// the result holds stable while out_stall is high
// reset restores the default time bases and forgets the last stamps
// config writes are taken through cfg_we/cfg_idx/cfg_wdata; the user must
// write them only while idle, the block does not enforce it
`include "packet_timestamp_normalizer_macros.svh"
module packet_timestamp_normalizer #(
	parameter int STAMP_BITS = 63
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [31:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               pts_present,
	input  logic signed [62:0] pts_in,
	input  logic               dts_present,
	input  logic signed [62:0] dts_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [62:0] pts_out,
	output logic signed [62:0] dts_out,
	output logic               pts_made_up,
	output logic               pts_bumped,
	output logic               dts_bumped,
	output logic               pts_raised_to_dts
);
	ptn_pkg::cmd_t  cmd;
	ptn_pkg::stat_t stat;
	logic busy;
	logic pts_present_l, dts_present_l, pp_h_q, dp_h_q;

	assign in_stall = busy;

	ptn_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_go(in_valid), .dts_p(dts_present_l),
		.pts_p(pts_present_l), .out_taken(!out_stall), .stat(stat), .cmd(cmd),
		.busy(busy), .out_valid(out_valid)
	);

	// flags seen by the controller: live at accept, held afterward
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pp_h_q <= pts_present;
			dp_h_q <= dts_present;
		end
	end
	assign pts_present_l = busy ? pp_h_q : pts_present;
	assign dts_present_l = busy ? dp_h_q : dts_present;

	ptn_datapath #(.STAMP_BITS(STAMP_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .cfg_we(cfg_we),
		.cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata), .pts_present(pts_present),
		.pts_in(pts_in), .dts_present(dts_present), .dts_in(dts_in),
		.pts_out(pts_out), .dts_out(dts_out), .pts_made_up(pts_made_up),
		.pts_bumped(pts_bumped), .dts_bumped(dts_bumped),
		.pts_raised_to_dts(pts_raised_to_dts)
	);

	`PTN_ASSERT_IMPL(a_no_accept_busy, clk, arst_n, out_valid, in_stall)
	`PTN_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(pts_out))
	`PTN_ASSERT_IMPL(a_raise_order, clk, arst_n, out_valid && !pts_raised_to_dts, pts_out >= dts_out)
endmodule
